// ===== hdl/aces_pkg.sv =====
// Shared types, codes and the basic colour table of the CSI escape parser.
`default_nettype none

package aces_pkg;

	localparam int COLUMN_BITS_DEF = 10;
	localparam int WIDTH_BITS = 11;
	localparam int RGB_BITS = 24;
	localparam int VALUE_BITS = 16;
	localparam int DCOUNT_BITS = 3;

	localparam logic [WIDTH_BITS-1:0] SCREEN_WIDTH_RST = 11'd80;
	localparam logic [RGB_BITS-1:0] DEFAULT_FG_RST = 24'hffffff;
	localparam logic [RGB_BITS-1:0] DEFAULT_BG_RST = 24'h000000;

	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH = 2'd0,
		CFG_DEFAULT_FG   = 2'd1,
		CFG_DEFAULT_BG   = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ACT_LEFT      = 4'd0,
		ACT_DOWN      = 4'd1,
		ACT_RETURN    = 4'd2,
		ACT_PUT       = 4'd3,
		ACT_CLR_END   = 4'd4,
		ACT_CLR_START = 4'd5,
		ACT_CLR_SCR   = 4'd6,
		ACT_CLR_ALL   = 4'd7,
		ACT_SET_FG    = 4'd8,
		ACT_SET_BG    = 4'd9
	} action_t;

	typedef enum logic [2:0] {
		MODE_GROUND = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_CSI    = 3'b100
	} mode_t;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_LBR = 8'h5b;
	localparam logic [7:0] CH_J   = 8'h4a;
	localparam logic [7:0] CH_M   = 8'h6d;
	localparam logic [7:0] CH_0   = 8'h30;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] char_code;
		logic [RGB_BITS-1:0] rgb;
		logic last;
	} result_t;

	function automatic logic [RGB_BITS-1:0] basic_palette(input logic [2:0] idx);
		logic [RGB_BITS-1:0] c;
		case (idx)
			3'd0: c = 24'h000000;
			3'd1: c = 24'h800000;
			3'd2: c = 24'h008000;
			3'd3: c = 24'h808000;
			3'd4: c = 24'h000080;
			3'd5: c = 24'h800080;
			3'd6: c = 24'h008080;
			3'd7: c = 24'hc0c0c0;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ansi_csi_escape_parser.sv =====
// Top level: ANSI CSI escape parser with input register and result queue.
`default_nettype none

// Takes one terminal byte per word with the cursor column and gives zero, one or two
// display actions per byte in stream order; last_of_run marks the final action of a
// byte. A byte is latched in an input register and decoded from there by a
// single pass of logic that updates the parser state and writes its actions into a
// four-word result queue. One byte per cycle is sustained while each byte gives at
// most one action and the output side keeps up; a byte that wraps gives two actions,
// and the output moves one word per cycle while act_stall is low.
// Configuration is taken at any time (cfg_ready is always high) but must only be
// written while the block is idle.
module ansi_csi_escape_parser
	import aces_pkg::*;
#(
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire logic [7:0]             byte_in,
	input  wire logic [COLUMN_BITS-1:0] cursor_column,
	output logic                        act_valid,
	input  wire logic                   act_stall,
	output logic [3:0]                  action,
	output logic [7:0]                  char_code,
	output logic [RGB_BITS-1:0]         rgb_color,
	output logic                        last_of_run,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [RGB_BITS-1:0]    cfg_data
);

	localparam int CMP_W = ((COLUMN_BITS > WIDTH_BITS) ? COLUMN_BITS : WIDTH_BITS) + 1;

	// configuration
	logic [WIDTH_BITS-1:0] screen_width_q;
	logic [RGB_BITS-1:0] default_fg_q;
	logic [RGB_BITS-1:0] default_bg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			default_fg_q <= DEFAULT_FG_RST;
			default_bg_q <= DEFAULT_BG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_SCREEN_WIDTH: screen_width_q <= cfg_data[WIDTH_BITS-1:0];
				CFG_DEFAULT_FG: default_fg_q <= cfg_data;
				CFG_DEFAULT_BG: default_bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1;
	logic [7:0] byte_s1;
	logic [COLUMN_BITS-1:0] col_s1;
	logic [2:0] count_q;
	logic advance;

	assign advance = valid_s1 && (count_q <= 3'd2);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_in;
			col_s1 <= cursor_column;
		end
	end

	// parser state
	mode_t mode_q, mode_d;
	logic [VALUE_BITS-1:0] value_q, value_d;
	logic [DCOUNT_BITS-1:0] dcount_q, dcount_d;
	logic ended_q, ended_d;
	logic nonempty_q, nonempty_d;
	logic alldig_q, alldig_d;

	logic [1:0] n_res;
	result_t r0, r1;

	logic is_letter, is_digit, do_ground, wrap;
	logic [19:0] value_x10;
	logic [VALUE_BITS-1:0] op_j, op_m30;

	always_comb begin
		is_letter = (byte_s1 inside {[8'h41:8'h5a], [8'h61:8'h7a]});
		is_digit = (byte_s1 inside {[8'h30:8'h39]});
		wrap = (CMP_W'(col_s1) + CMP_W'(1)) >= CMP_W'(screen_width_q);
		value_x10 = ({4'd0, value_q} << 3) + ({4'd0, value_q} << 1)
			+ 20'(byte_s1 - CH_0);
		op_j = nonempty_q ? value_q : '0;
		op_m30 = value_q - VALUE_BITS'(30);

		mode_d = mode_q;
		value_d = value_q;
		dcount_d = dcount_q;
		ended_d = ended_q;
		nonempty_d = nonempty_q;
		alldig_d = alldig_q;
		n_res = 2'd0;
		r0 = '0;
		r1 = '0;
		do_ground = 1'b0;

		case (mode_q)
			MODE_CSI: begin
				if (is_letter) begin
					if (byte_s1 == CH_J) begin
						if (alldig_q && op_j <= VALUE_BITS'(3)) begin
							r0.action = ACT_CLR_END + op_j[3:0];
							n_res = 2'd1;
						end
					end else if (byte_s1 == CH_M && dcount_q != '0) begin
						if (value_q inside {[16'd30:16'd37]}) begin
							r0.action = ACT_SET_FG;
							r0.rgb = basic_palette(op_m30[2:0]);
							n_res = 2'd1;
						end else if (value_q == 16'd39) begin
							r0.action = ACT_SET_FG;
							r0.rgb = default_fg_q;
							n_res = 2'd1;
						end else if (value_q inside {[16'd40:16'd47]}) begin
							r0.action = ACT_SET_BG;
							r0.rgb = basic_palette(value_q[2:0]);
							n_res = 2'd1;
						end else if (value_q == 16'd49) begin
							r0.action = ACT_SET_BG;
							r0.rgb = default_bg_q;
							n_res = 2'd1;
						end
					end
					mode_d = MODE_GROUND;
					value_d = '0;
					dcount_d = '0;
					ended_d = 1'b0;
					nonempty_d = 1'b0;
					alldig_d = 1'b1;
				end else begin
					nonempty_d = 1'b1;
					if (is_digit) begin
						if (!ended_q) begin
							value_d = (value_x10[19:16] != 4'd0) ? '1 : value_x10[15:0];
							if (dcount_q != '1)
								dcount_d = dcount_q + DCOUNT_BITS'(1);
						end
					end else begin
						ended_d = 1'b1;
						alldig_d = 1'b0;
					end
				end
			end
			MODE_ESCAPE: begin
				if (byte_s1 == CH_LBR) begin
					mode_d = MODE_CSI;
					value_d = '0;
					dcount_d = '0;
					ended_d = 1'b0;
					nonempty_d = 1'b0;
					alldig_d = 1'b1;
				end else begin
					mode_d = MODE_GROUND;
					do_ground = 1'b1;
				end
			end
			default: begin
				do_ground = 1'b1;
			end
		endcase

		if (do_ground) begin
			case (byte_s1)
				CH_ESC: mode_d = MODE_ESCAPE;
				CH_BEL: ;
				CH_BS: begin
					r0.action = ACT_LEFT;
					n_res = 2'd1;
				end
				CH_LF: begin
					r0.action = ACT_DOWN;
					n_res = 2'd1;
				end
				CH_CR: begin
					r0.action = ACT_RETURN;
					n_res = 2'd1;
				end
				default: begin
					r0.action = ACT_PUT;
					if (wrap) begin
						r0.char_code = CH_LF;
						r1.action = ACT_PUT;
						r1.char_code = byte_s1;
						n_res = 2'd2;
					end else begin
						r0.char_code = byte_s1;
						n_res = 2'd1;
					end
				end
			endcase
		end

		r0.last = (n_res == 2'd1);
		r1.last = (n_res == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GROUND;
			value_q <= '0;
			dcount_q <= '0;
			ended_q <= 1'b0;
			nonempty_q <= 1'b0;
			alldig_q <= 1'b1;
		end else if (advance) begin
			mode_q <= mode_d;
			value_q <= value_d;
			dcount_q <= dcount_d;
			ended_q <= ended_d;
			nonempty_q <= nonempty_d;
			alldig_q <= alldig_d;
		end
	end

	// result queue, four words
	result_t queue_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [1:0] push_n;
	logic pop;
	result_t head;

	assign push_n = advance ? n_res : 2'd0;
	assign pop = act_valid && !act_stall;
	assign head = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			queue_q[wr_ptr_q] <= r0;
		if (push_n == 2'd2)
			queue_q[wr_ptr_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

	assign act_valid = (count_q != 3'd0);
	assign action = head.action;
	assign char_code = head.char_code;
	assign rgb_color = head.rgb;
	assign last_of_run = head.last;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && count_q >= 3'd3))
		else $error("input stalled without a full queue");

	a_wrap_first: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (r0.action == ACT_PUT && r0.char_code == CH_LF && !r0.last))
		else $error("two-word run does not open with a wrap newline");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 3'd0 && push_n == 2'd0) |=> (count_q == 3'd0))
		else $error("queue count moved without a push");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the CSI escape parser: random byte streams, colour and width phases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import aces_pkg::*;

	localparam int COL_BITS = COLUMN_BITS_DEF;
	localparam int WATCH_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES = 8;
	localparam int BYTES_PER_PHASE = 195;

	localparam logic [RGB_BITS-1:0] SGR_COLOURS [0:7] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h808000,
		24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0
	};

	// Predicts the display actions of each byte and holds them until they arrive.
	class action_board;
		logic [WIDTH_BITS-1:0] scr_width;
		logic [RGB_BITS-1:0] fg_default;
		logic [RGB_BITS-1:0] bg_default;
		mode_t mode;
		logic [VALUE_BITS-1:0] acc;
		logic [DCOUNT_BITS-1:0] ndigits;
		bit run_done;
		bit seen_any;
		bit only_digits;
		result_t fresh[$];
		result_t pending_actions[$];
		int errors;

		function new();
			scr_width = SCREEN_WIDTH_RST;
			fg_default = DEFAULT_FG_RST;
			bg_default = DEFAULT_BG_RST;
			mode = MODE_GROUND;
			clear_param();
			errors = 0;
		endfunction

		static function bit is_letter(logic [7:0] b);
			return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
		endfunction

		function void clear_param();
			acc = '0;
			ndigits = '0;
			run_done = 1'b0;
			seen_any = 1'b0;
			only_digits = 1'b1;
		endfunction

		function result_t word_of(action_t a, logic [7:0] ch, logic [RGB_BITS-1:0] rgb);
			result_t r;
			r.action = a;
			r.char_code = ch;
			r.rgb = rgb;
			r.last = 1'b0;
			return r;
		endfunction

		function void set_reg(logic [1:0] idx, logic [RGB_BITS-1:0] d);
			case (cfg_index_t'(idx))
				CFG_SCREEN_WIDTH: scr_width = d[WIDTH_BITS-1:0];
				CFG_DEFAULT_FG: fg_default = d;
				CFG_DEFAULT_BG: bg_default = d;
				default: ;
			endcase
		endfunction

		function void ground_byte(logic [7:0] b, logic [COL_BITS-1:0] col);
			case (b)
				CH_ESC: mode = MODE_ESCAPE;
				CH_BEL: ;
				CH_BS: fresh.push_back(word_of(ACT_LEFT, 8'h00, '0));
				CH_LF: fresh.push_back(word_of(ACT_DOWN, 8'h00, '0));
				CH_CR: fresh.push_back(word_of(ACT_RETURN, 8'h00, '0));
				default: begin
					// auto wrap once the cursor sits on or past the last column
					if (int'(col) + 1 >= int'(scr_width))
						fresh.push_back(word_of(ACT_PUT, CH_LF, '0));
					fresh.push_back(word_of(ACT_PUT, b, '0));
				end
			endcase
		endfunction

		function void close_sequence(logic [7:0] fin);
			logic [VALUE_BITS-1:0] op;
			if (fin == CH_J) begin
				op = seen_any ? acc : '0;
				if (only_digits) begin
					case (op)
						16'd0: fresh.push_back(word_of(ACT_CLR_END, 8'h00, '0));
						16'd1: fresh.push_back(word_of(ACT_CLR_START, 8'h00, '0));
						16'd2: fresh.push_back(word_of(ACT_CLR_SCR, 8'h00, '0));
						16'd3: fresh.push_back(word_of(ACT_CLR_ALL, 8'h00, '0));
						default: ;
					endcase
				end
			end else if (fin == CH_M && ndigits != 0) begin
				// only the leading number counts; 38 and 48 fall through unanswered
				if (acc >= 16'd30 && acc <= 16'd37)
					fresh.push_back(word_of(ACT_SET_FG, 8'h00, SGR_COLOURS[3'(acc - 16'd30)]));
				else if (acc == 16'd39)
					fresh.push_back(word_of(ACT_SET_FG, 8'h00, fg_default));
				else if (acc >= 16'd40 && acc <= 16'd47)
					fresh.push_back(word_of(ACT_SET_BG, 8'h00, SGR_COLOURS[3'(acc - 16'd40)]));
				else if (acc == 16'd49)
					fresh.push_back(word_of(ACT_SET_BG, 8'h00, bg_default));
			end
		endfunction

		function void note_byte(logic [7:0] b, logic [COL_BITS-1:0] col);
			int v;
			fresh.delete();
			case (mode)
				MODE_CSI: begin
					if (is_letter(b)) begin
						close_sequence(b);
						mode = MODE_GROUND;
						clear_param();
					end else begin
						seen_any = 1'b1;
						if (b >= CH_0 && b <= 8'h39) begin
							if (!run_done) begin
								v = int'(acc) * 10 + int'(b - CH_0);
								acc = (v > 65535) ? 16'hffff : v[15:0];
								if (ndigits != 3'd7)
									ndigits++;
							end
						end else begin
							run_done = 1'b1;
							only_digits = 1'b0;
						end
					end
				end
				MODE_ESCAPE: begin
					if (b == CH_LBR) begin
						mode = MODE_CSI;
						clear_param();
					end else begin
						mode = MODE_GROUND;
						ground_byte(b, col);
					end
				end
				default: ground_byte(b, col);
			endcase
			if (fresh.size() != 0)
				fresh[fresh.size()-1].last = 1'b1;
			foreach (fresh[i])
				pending_actions.push_back(fresh[i]);
		endfunction

		function void check_action(logic [3:0] a, logic [7:0] ch, logic [RGB_BITS-1:0] rgb,
				logic l);
			result_t e;
			if (pending_actions.size() == 0) begin
				$display("%0t: unexpected word: action %0d char %02h rgb %06h last %0b",
					$time, a, ch, rgb, l);
				errors++;
				return;
			end
			e = pending_actions.pop_front();
			if (a !== e.action) begin
				$display("%0t: action expected %0d got %0d", $time, e.action, a);
				errors++;
			end
			if (ch !== e.char_code) begin
				$display("%0t: char_code expected %02h got %02h", $time, e.char_code, ch);
				errors++;
			end
			if (rgb !== e.rgb) begin
				$display("%0t: rgb_color expected %06h got %06h", $time, e.rgb, rgb);
				errors++;
			end
			if (l !== e.last) begin
				$display("%0t: last_of_run expected %0b got %0b", $time, e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] byte_in = '0;
	logic [COL_BITS-1:0] cursor_column = '0;
	logic act_valid;
	logic act_stall = 1'b0;
	logic [3:0] action;
	logic [7:0] char_code;
	logic [RGB_BITS-1:0] rgb_color;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [RGB_BITS-1:0] cfg_data = '0;

	action_board board = new();
	bit hold_req = 1'b0;
	bit send_quiet = 1'b0;
	int idle_cycles = 0;
	logic [7:0] run_bytes[$];

	ansi_csi_escape_parser dut (.*);

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				board.note_byte(byte_in, cursor_column);
			if (act_valid && !act_stall)
				board.check_action(action, char_code, rgb_color, last_of_run);
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
			if ((byte_valid && !byte_stall) || (act_valid && !act_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCH_LIMIT);
		$display("ansi_csi_escape_parser verification failed");
		$finish;
	end

	// Output side: random stall per word, quiet stretches, and one long hold-off on request.
	initial begin
		int n;
		int left;
		bit quiet;
		left = 0;
		quiet = 1'b0;
		wait (arst_n);
		forever begin
			if (left == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
				left = $urandom_range(20, 80);
			end
			left--;
			if (hold_req) begin
				act_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				act_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 9);
				if (n != 0) begin
					act_stall <= 1'b1;
					repeat (n) @(posedge clk);
					act_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!(act_valid && arst_n));
		end
	end

	task automatic send_byte(input logic [7:0] b, input int col);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		cursor_column <= COL_BITS'(col);
		do @(posedge clk); while (byte_stall);
	endtask

	// Wait for every expected word, then let any silent byte settle.
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [RGB_BITS-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [WIDTH_BITS-1:0] w, input logic [RGB_BITS-1:0] fg,
			input logic [RGB_BITS-1:0] bg);
		write_reg(CFG_SCREEN_WIDTH, {{(RGB_BITS-WIDTH_BITS){1'b0}}, w});
		write_reg(CFG_DEFAULT_FG, fg);
		write_reg(CFG_DEFAULT_BG, bg);
		cfg_valid <= 1'b0;
	endtask

	// Half anywhere, half just around the wrap point of the current width.
	function automatic logic [COL_BITS-1:0] pick_column();
		int c;
		if ($urandom_range(0, 1) == 0)
			return COL_BITS'($urandom_range(0, (1 << COL_BITS) - 1));
		c = int'(board.scr_width) - 3 + $urandom_range(0, 3);
		if (c < 0)
			c = 0;
		if (c > (1 << COL_BITS) - 1)
			c = (1 << COL_BITS) - 1;
		return c[COL_BITS-1:0];
	endfunction

	function automatic void push_number(int n);
		string s;
		s = $sformatf("%0d", n);
		for (int i = 0; i < s.len(); i++)
			run_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] non_letter();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (action_board::is_letter(b));
		return b;
	endfunction

	// One run: text, a control byte, a CSI sequence (mostly well formed) or a stray ESC.
	function automatic void make_run();
		int kind;
		int p;
		int code;
		logic [7:0] b;
		logic [7:0] fin;
		run_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			repeat ($urandom_range(1, 6)) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_ESC)
					b = 8'h20;
				run_bytes.push_back(b);
			end
		end else if (kind < 45) begin
			case ($urandom_range(0, 3))
				0: run_bytes.push_back(CH_BEL);
				1: run_bytes.push_back(CH_BS);
				2: run_bytes.push_back(CH_LF);
				default: run_bytes.push_back(CH_CR);
			endcase
		end else if (kind < 85) begin
			run_bytes.push_back(CH_ESC);
			run_bytes.push_back(CH_LBR);
			p = $urandom_range(0, 9);
			if (p < 4)
				fin = CH_J;
			else if (p < 8)
				fin = CH_M;
			else if (p == 8)
				fin = 8'h41 + 8'($urandom_range(0, 25));
			else
				fin = 8'h61 + 8'($urandom_range(0, 25));
			code = (fin == CH_J) ? $urandom_range(0, 5) : $urandom_range(28, 50);
			p = $urandom_range(0, 99);
			if (p < 15) begin
			end else if (p < 70) begin
				push_number(code);
			end else if (p < 80) begin
				push_number(code);
				run_bytes.push_back(8'h3b);
				push_number($urandom_range(0, 255));
			end else if (p < 88) begin
				// long digit strings can push the value into saturation
				repeat ($urandom_range(6, 12))
					run_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
			end else if (p < 95) begin
				repeat ($urandom_range(1, 4))
					run_bytes.push_back(non_letter());
			end else begin
				run_bytes.push_back(CH_0);
				run_bytes.push_back(CH_0);
				push_number(code);
			end
			run_bytes.push_back(fin);
		end else begin
			run_bytes.push_back(CH_ESC);
			if ($urandom_range(0, 3) != 0)
				run_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		int sent;
		logic [WIDTH_BITS-1:0] w;
		logic [RGB_BITS-1:0] fg;
		logic [RGB_BITS-1:0] bg;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset settings (width 80)
		send_byte(8'h00, 0);
		send_byte(8'h41, 79);
		send_byte(8'hff, 1023);
		send_byte(CH_BEL, 5);
		send_byte(CH_BS, 5);
		send_byte(CH_LF, 5);
		send_byte(CH_CR, 5);
		send_byte(CH_ESC, 0);
		send_byte(8'h78, 0);
		send_byte(CH_ESC, 0);
		send_byte(CH_LBR, 0);
		send_byte(CH_J, 0);
		send_byte(CH_ESC, 0);
		send_byte(CH_LBR, 0);
		send_byte(8'h34, 0);
		send_byte(8'h39, 0);
		send_byte(CH_M, 0);
		send_byte(CH_ESC, 0);
		send_byte(CH_LBR, 0);
		send_byte(8'h33, 0);
		send_byte(8'h39, 0);
		send_byte(CH_M, 0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			fg = RGB_BITS'($urandom_range(0, 24'hffffff));
			bg = RGB_BITS'($urandom_range(0, 24'hffffff));
			case (phase)
				0: begin
					w = 11'd1;
					fg = 24'h000000;
					bg = 24'hffffff;
				end
				1: begin
					w = 11'd1024;
					fg = 24'hffffff;
					bg = 24'h000000;
				end
				2: w = 11'd0;
				3: w = 11'h7ff;
				default: w = WIDTH_BITS'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 24)
					: $urandom_range(1, 1024));
			endcase
			set_regs(w, fg, bg);

			if (phase == 1) begin
				// output held off while input keeps coming, so the block backs up
				hold_req = 1'b1;
				send_quiet = 1'b1;
				repeat (60)
					send_byte(8'($urandom_range(8'h20, 8'h7e)), pick_column());
				send_quiet = 1'b0;
			end

			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				if ($urandom_range(0, 39) == 0)
					send_quiet = !send_quiet;
				make_run();
				foreach (run_bytes[i])
					send_byte(run_bytes[i], pick_column());
				sent += run_bytes.size();
			end
			send_quiet = 1'b0;
			drain();
		end

		if (board.errors == 0 && board.pending_actions.size() == 0)
			$display("ansi_csi_escape_parser verification clean");
		else
			$display("ansi_csi_escape_parser verification failed");
		$finish;
	end

endmodule

// ===== ansi_csi_escape_parser.f =====
hdl/aces_pkg.sv
hdl/ansi_csi_escape_parser.sv
bench/tb_top.sv
